// ----- hw/rtl/bfa_pkg.sv -----
// ----------------------------------------------------------------------------
// bfa_pkg
// shared types and constants of the bitmap frame allocator
// ----------------------------------------------------------------------------
package bfa_pkg;

  // frames covered by the bitmap, one used bit each
  localparam int unsigned NUM_FRAMES = 4096;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned BIT_AW     = $clog2(WORD_W);
  localparam int unsigned BM_WORDS   = (NUM_FRAMES + WORD_W - 1) / WORD_W;
  localparam int unsigned WORD_AW    = $clog2(BM_WORDS);
  // scan limit counts words up to and including BM_WORDS
  localparam int unsigned LIMIT_W    = WORD_AW + 1;

  // payload widths fixed by the interface
  localparam int unsigned FRAME_W    = 12;
  localparam int unsigned ENTRY_W    = 20;
  localparam int unsigned USABLE_W   = 13;
  localparam int unsigned USABLE_RST = 4096;

  // apb
  localparam int unsigned APB_AW     = 3;
  localparam int unsigned APB_DW     = 32;

  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [WORD_AW-1:0] word_addr_t;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_MARK  = 2'd1,
    OP_TEST  = 2'd2
  } bfa_opcode_e;

  typedef enum logic [1:0] {
    STATUS_DONE   = 2'd0,
    STATUS_MAPPED = 2'd1,
    STATUS_FULL   = 2'd2
  } bfa_status_e;

  // register index on the apb port
  typedef enum logic {
    REG_USABLE_FRAMES = 1'b0
  } bfa_reg_e;

  typedef struct packed {
    logic       rd_en;
    word_addr_t rd_addr;
    logic       wr_en;
    word_addr_t wr_addr;
    word_t      wr_data;
  } bfa_mem_req_t;

  typedef struct packed {
    bfa_status_e        status;
    logic [FRAME_W-1:0] frame;
    logic               present;
    logic               rw;
    logic               user;
    logic               in_use;
  } bfa_result_t;

endpackage

// ----- hw/rtl/bfa_bitmap_ram.sv -----
// ----------------------------------------------------------------------------
// bfa_bitmap_ram
// bitmap word memory, one read and one write port, registered read data
// ----------------------------------------------------------------------------
module bfa_bitmap_ram
  import bfa_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  bfa_mem_req_t req_i,
  output word_t        rd_data_o
);

  word_t                mem [BM_WORDS];
  logic  [BM_WORDS-1:0] vld_q;
  word_t                data_q;
  logic                 hit_q;

  // word storage, no reset
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      data_q <= mem[req_i.rd_addr];
    end
  end

  // per-word written flags, a word never written reads as all free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      hit_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        hit_q <= vld_q[req_i.rd_addr];
      end
    end
  end

  assign rd_data_o = hit_q ? data_q : '0;

endmodule

// ----- hw/rtl/bfa_apb_regs.sv -----
// ----------------------------------------------------------------------------
// bfa_apb_regs
// apb configuration register holding the usable frame count
// ----------------------------------------------------------------------------
module bfa_apb_regs
  import bfa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready,
  output logic [USABLE_W-1:0] usable_frames_o
);

  logic [USABLE_W-1:0] usable_q;
  bfa_reg_e            reg_sel;

  assign reg_sel = bfa_reg_e'(paddr[APB_AW-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      usable_q <= USABLE_W'(USABLE_RST);
    end else if (psel && penable && pwrite && (reg_sel == REG_USABLE_FRAMES)) begin
      usable_q <= pwdata[USABLE_W-1:0];
    end
  end

  always_comb begin
    case (reg_sel)
      REG_USABLE_FRAMES: prdata = {{(APB_DW-USABLE_W){1'b0}}, usable_q};
      default:           prdata = '0;
    endcase
  end

  assign pready          = 1'b1;
  assign usable_frames_o = usable_q;

endmodule

// ----- hw/rtl/bfa_ctrl.sv -----
// ----------------------------------------------------------------------------
// bfa_ctrl
// operation sequencer: word scan, read-modify-write, result register
// ----------------------------------------------------------------------------
module bfa_ctrl
  import bfa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [USABLE_W-1:0] usable_frames_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          opcode_i,
  input  logic [FRAME_W-1:0]  frame_index_i,
  input  logic [ENTRY_W-1:0]  entry_frame_i,
  input  logic                is_kernel_i,
  input  logic                is_writeable_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bfa_result_t         result_o,
  output bfa_mem_req_t        mem_req_o,
  input  word_t               rd_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_TEST,
    ST_RESP
  } state_e;

  state_e               state_q;
  logic [LIMIT_W-1:0]   ptr_q;
  logic [LIMIT_W-1:0]   limit_q;
  logic [LIMIT_W-1:0]   limit_d;
  logic                 pending_q;
  word_addr_t           chk_addr_q;
  logic [FRAME_W-1:0]   fidx_q;
  logic                 kern_q;
  logic                 wr_q;
  bfa_result_t          res_q;
  bfa_result_t          out_q;
  logic                 out_valid_q;

  logic                 accept;
  logic                 issue;
  logic                 found;
  logic [BIT_AW-1:0]    found_bit;
  logic                 slot_free;
  logic [USABLE_W-BIT_AW-1:0] usable_words;

  // lowest clear bit of a word
  function automatic logic [BIT_AW-1:0] lowest_zero(input word_t w);
    logic [BIT_AW-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!w[i]) begin
        idx = BIT_AW'(i);
      end
    end
    return idx;
  endfunction

  assign usable_words = usable_frames_i[USABLE_W-1:BIT_AW];

  always_comb begin
    if (usable_words > (USABLE_W-BIT_AW)'(BM_WORDS)) begin
      limit_d = LIMIT_W'(BM_WORDS);
    end else begin
      limit_d = LIMIT_W'(usable_words);
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign issue      = (state_q == ST_SCAN) && (ptr_q < limit_q);
  assign found      = (state_q == ST_SCAN) && pending_q && (rd_data_i != '1);
  assign found_bit  = lowest_zero(rd_data_i);
  assign slot_free  = !out_valid_q || out_ready_i;

  // memory requests
  always_comb begin
    mem_req_o = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept && (bfa_opcode_e'(opcode_i) == OP_MARK ||
                       bfa_opcode_e'(opcode_i) == OP_TEST)) begin
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = frame_index_i[FRAME_W-1:BIT_AW];
        end
      end
      ST_SCAN: begin
        mem_req_o.rd_en   = issue;
        mem_req_o.rd_addr = ptr_q[WORD_AW-1:0];
        if (found) begin
          mem_req_o.wr_en   = 1'b1;
          mem_req_o.wr_addr = chk_addr_q;
          mem_req_o.wr_data = rd_data_i | (word_t'(1) << found_bit);
        end
      end
      ST_MARK: begin
        mem_req_o.wr_en   = 1'b1;
        mem_req_o.wr_addr = fidx_q[FRAME_W-1:BIT_AW];
        mem_req_o.wr_data = rd_data_i | (word_t'(1) << fidx_q[BIT_AW-1:0]);
      end
      default: begin
        mem_req_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ptr_q       <= '0;
      limit_q     <= '0;
      pending_q   <= 1'b0;
      chk_addr_q  <= '0;
      fidx_q      <= '0;
      kern_q      <= 1'b0;
      wr_q        <= 1'b0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // a result moving into the slot this cycle sets valid below instead
      if (out_ready_i && (state_q != ST_RESP)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            res_q  <= '0;
            fidx_q <= frame_index_i;
            kern_q <= is_kernel_i;
            wr_q   <= is_writeable_i;
            case (bfa_opcode_e'(opcode_i))
              OP_ALLOC: begin
                if (entry_frame_i != '0) begin
                  res_q.status <= STATUS_MAPPED;
                  state_q      <= ST_RESP;
                end else if (limit_d == '0) begin
                  res_q.status <= STATUS_FULL;
                  state_q      <= ST_RESP;
                end else begin
                  ptr_q     <= '0;
                  pending_q <= 1'b0;
                  limit_q   <= limit_d;
                  state_q   <= ST_SCAN;
                end
              end
              OP_MARK: begin
                state_q <= ST_MARK;
              end
              OP_TEST: begin
                state_q <= ST_TEST;
              end
              default: begin
                state_q <= ST_RESP;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (found) begin
            res_q.status  <= STATUS_DONE;
            res_q.frame   <= {chk_addr_q, found_bit};
            res_q.present <= 1'b1;
            res_q.rw      <= wr_q;
            res_q.user    <= !kern_q;
            state_q       <= ST_RESP;
          end else if (issue) begin
            ptr_q      <= ptr_q + LIMIT_W'(1);
            chk_addr_q <= ptr_q[WORD_AW-1:0];
            pending_q  <= 1'b1;
          end else if (pending_q) begin
            // last word in flight was full
            pending_q <= 1'b0;
          end else begin
            res_q.status <= STATUS_FULL;
            state_q      <= ST_RESP;
          end
        end
        ST_MARK: begin
          state_q <= ST_RESP;
        end
        ST_TEST: begin
          res_q.in_use <= rd_data_i[fidx_q[BIT_AW-1:0]];
          state_q      <= ST_RESP;
        end
        ST_RESP: begin
          if (slot_free) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

`ifndef SYNTHESIS
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !mem_req_o.wr_en)
    else $error("bitmap written while idle");

  a_scan_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (ptr_q <= limit_q) && (limit_q <= LIMIT_W'(BM_WORDS)))
    else $error("scan pointer past limit");

  a_found_to_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && mem_req_o.wr_en) |=> (state_q == ST_RESP) && res_q.present)
    else $error("allocation write without result");

  a_present_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.present |-> (out_q.status == STATUS_DONE) && !out_q.in_use)
    else $error("present bit on a failed allocation");
`endif

endmodule

// ----- hw/rtl/bitmap_frame_allocator_core.sv -----
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_core
// physical frame allocator keeping one used bit per frame
// ----------------------------------------------------------------------------
// usage
//   items enter on the in_* valid/ready channel: opcode allocate, mark or
//   test, with frame index, current page entry frame and kernel/writeable
//   flags. each item gives exactly one result item on the out_* channel:
//   status, allocated frame and its present/rw/user bits, and in_use.
//   usable_frames is to be written over the apb port only while no item is in
//   flight; the block itself does not enforce this.
// sequencing
//   one item at a time, the bitmap memory has one read port with registered
//   read data. mark reads the addressed word and writes it back with the
//   bit set, test reads it and takes its bit. allocate reads one bitmap word
//   per cycle from word 0, at most all 128 words, and writes the first free
//   bit back as used; a mapped entry or an empty range skips the scan.
// reset
//   bitmap reads as all free right after reset (per-word written flags are
//   cleared, no clearing sweep), usable_frames returns to 4096.
// stall
//   a result waits in the output register; the next item is taken while it
//   waits, and its own result holds in the sequencer until the slot frees.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_core
  import bfa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // apb configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready,
  // request items
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          opcode_i,
  input  logic [FRAME_W-1:0]  frame_index_i,
  input  logic [ENTRY_W-1:0]  entry_frame_i,
  input  logic                is_kernel_i,
  input  logic                is_writeable_i,
  // result items
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          status_o,
  output logic [FRAME_W-1:0]  alloc_frame_index_o,
  output logic                present_bit_o,
  output logic                rw_bit_o,
  output logic                user_bit_o,
  output logic                in_use_o
);

  logic [USABLE_W-1:0] usable_frames;
  bfa_mem_req_t        mem_req;
  word_t               rd_data;
  bfa_result_t         result;

  // configuration register
  bfa_apb_regs u_regs (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .usable_frames_o (usable_frames)
  );

  // sequencer: scan, read-modify-write and result register
  bfa_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .usable_frames_i (usable_frames),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .frame_index_i   (frame_index_i),
    .entry_frame_i   (entry_frame_i),
    .is_kernel_i     (is_kernel_i),
    .is_writeable_i  (is_writeable_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .result_o        (result),
    .mem_req_o       (mem_req),
    .rd_data_i       (rd_data)
  );

  // bitmap words, frame f sits in word f/32 bit f%32
  bfa_bitmap_ram u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  assign status_o            = result.status;
  assign alloc_frame_index_o = result.frame;
  assign present_bit_o       = result.present;
  assign rw_bit_o            = result.rw;
  assign user_bit_o          = result.user;
  assign in_use_o            = result.in_use;

endmodule

// ----- test/bitmap_frame_allocator_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_core_test
// self-checking bench for the bitmap frame allocator core
// ----------------------------------------------------------------------------
// drives allocate, mark and test items with random gaps on both channels,
// keeps a private copy of the frame bitmap to predict every result item and
// steps usable_frames through its extremes and partial-word settings
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_core_test
  import bfa_pkg::*;
();

  localparam logic [APB_AW-1:0] USABLE_ADDR = APB_AW'(4 * int'(REG_USABLE_FRAMES));
  localparam int unsigned OP_UNUSED = 3;

  // frame bitmap shadow plus the queue of predicted result items
  class frame_scoreboard;
    logic [WORD_W-1:0] used_map [BM_WORDS];
    int unsigned       usable;
    bfa_result_t       pending_results [$];
    int unsigned       errors;
    int unsigned       n_items;
    int unsigned       n_granted;
    int unsigned       n_mapped;
    int unsigned       n_full;
    int unsigned       n_used_hits;

    function new();
      foreach (used_map[w]) used_map[w] = '0;
      usable = USABLE_RST;
    endfunction

    function void set_usable(int unsigned frames);
      usable = frames;
    endfunction

    // predict the result of one accepted item and update the shadow bitmap
    function void note_item(logic [1:0] op, logic [FRAME_W-1:0] fidx,
                            logic [ENTRY_W-1:0] entry, logic kern, logic wr);
      bfa_result_t res;
      int unsigned scan_limit;
      int          free_frame;
      res = '0;
      res.status = STATUS_DONE;
      free_frame = -1;
      n_items++;
      if (op == OP_ALLOC) begin
        if (entry != '0) begin
          res.status = STATUS_MAPPED;
          n_mapped++;
        end else begin
          // only whole words below usable_frames, never past the bitmap
          scan_limit = usable / WORD_W;
          if (scan_limit > BM_WORDS) scan_limit = BM_WORDS;
          for (int w = 0; w < scan_limit && free_frame < 0; w++) begin
            for (int b = 0; b < WORD_W && free_frame < 0; b++) begin
              if (!used_map[w][b]) free_frame = w * WORD_W + b;
            end
          end
          if (free_frame < 0) begin
            res.status = STATUS_FULL;
            n_full++;
          end else begin
            used_map[free_frame / WORD_W][free_frame % WORD_W] = 1'b1;
            res.frame   = FRAME_W'(free_frame);
            res.present = 1'b1;
            res.rw      = wr;
            res.user    = ~kern;
            n_granted++;
          end
        end
      end else if (op == OP_MARK) begin
        if (fidx < NUM_FRAMES) used_map[fidx / WORD_W][fidx % WORD_W] = 1'b1;
      end else if (op == OP_TEST) begin
        if (fidx < NUM_FRAMES) res.in_use = used_map[fidx / WORD_W][fidx % WORD_W];
        if (res.in_use) n_used_hits++;
      end
      pending_results.push_back(res);
    endfunction

    function void field_diff(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [1:0] st, logic [FRAME_W-1:0] fr, logic pr,
                               logic rw, logic us, logic iu);
      bfa_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result item with none pending, status %0h frame %0h",
                 $time, st, fr);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      field_diff("status", 32'(want.status), 32'(st));
      field_diff("alloc_frame_index", 32'(want.frame), 32'(fr));
      field_diff("present_bit", 32'(want.present), 32'(pr));
      field_diff("rw_bit", 32'(want.rw), 32'(rw));
      field_diff("user_bit", 32'(want.user), 32'(us));
      field_diff("in_use", 32'(want.in_use), 32'(iu));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  logic                in_valid_i;
  logic                in_ready_o;
  logic [1:0]          opcode_i;
  logic [FRAME_W-1:0]  frame_index_i;
  logic [ENTRY_W-1:0]  entry_frame_i;
  logic                is_kernel_i;
  logic                is_writeable_i;

  logic                out_valid_o;
  logic                out_ready_i;
  logic [1:0]          status_o;
  logic [FRAME_W-1:0]  alloc_frame_index_o;
  logic                present_bit_o;
  logic                rw_bit_o;
  logic                user_bit_o;
  logic                in_use_o;

  // when set neither side inserts gaps
  bit steady;
  frame_scoreboard sb;

  bitmap_frame_allocator_core u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .opcode_i            (opcode_i),
    .frame_index_i       (frame_index_i),
    .entry_frame_i       (entry_frame_i),
    .is_kernel_i         (is_kernel_i),
    .is_writeable_i      (is_writeable_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .status_o            (status_o),
    .alloc_frame_index_o (alloc_frame_index_o),
    .present_bit_o       (present_bit_o),
    .rw_bit_o            (rw_bit_o),
    .user_bit_o          (user_bit_o),
    .in_use_o            (in_use_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side back-pressure, ready low about 37 percent of the time
  always @(negedge clk_i) begin
    out_ready_i <= steady ? 1'b1 : ($urandom_range(99) >= 37);
  end

  // every accepted result item goes straight to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(status_o, alloc_frame_index_o, present_bit_o, rw_bit_o,
                      user_bit_o, in_use_o);
    end
  end

  // hard stop, several times the slowest legal run
  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // sender gaps: valid drops for a random number of cycles, never in steady mode
  task automatic sender_gap();
    if (!steady) begin
      while ($urandom_range(99) < 37) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
    end
  endtask

  // called just after a falling edge, returns just after a falling edge with
  // valid still high so a back-to-back item keeps it up
  task automatic send_item(logic [1:0] op, logic [FRAME_W-1:0] fidx,
                           logic [ENTRY_W-1:0] entry, logic kern, logic wr);
    sender_gap();
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    frame_index_i  <= fidx;
    entry_frame_i  <= entry;
    is_kernel_i    <= kern;
    is_writeable_i <= wr;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(op, fidx, entry, kern, wr);
    @(negedge clk_i);
  endtask

  // hold the request side off until every predicted result has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // apb write then read-back of usable_frames, only with the block idle
  task automatic write_usable(int unsigned frames);
    drain_results();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= USABLE_ADDR;
    pwdata  <= APB_DW'(frames);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== APB_DW'(frames)) begin
      $display("%0t: usable_frames read-back mismatch, expected %0h, got %0h",
               $time, frames, prdata);
      sb.errors++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_usable(frames);
  endtask

  // random items; frame numbers lean toward the low span so tests hit used bits
  task automatic random_items(int unsigned count, int unsigned alloc_pct,
                              int unsigned mark_pct, int unsigned span);
    int unsigned        pick;
    logic [1:0]         op;
    logic [FRAME_W-1:0] fidx;
    logic [ENTRY_W-1:0] entry;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < alloc_pct) op = OP_ALLOC;
      else if (pick < alloc_pct + mark_pct) op = OP_MARK;
      else if (pick < 97) op = OP_TEST;
      else op = 2'(OP_UNUSED);
      fidx = ($urandom_range(99) < 65) ? FRAME_W'($urandom_range(span - 1))
                                       : FRAME_W'($urandom_range(NUM_FRAMES - 1));
      pick = $urandom_range(99);
      if (pick < 80) entry = '0;
      else if (pick < 90) entry = ENTRY_W'(1) << $urandom_range(ENTRY_W - 1);
      else entry = ENTRY_W'($urandom_range(20'hFFFFF, 1));
      // now and then wait for the pipe to empty completely
      if ($urandom_range(99) < 2) drain_results();
      send_item(op, fidx, entry, 1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    sb             = new();
    steady         = 1'b0;
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid_i     = 1'b0;
    opcode_i       = OP_ALLOC;
    frame_index_i  = '0;
    entry_frame_i  = '0;
    is_kernel_i    = 1'b0;
    is_writeable_i = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part at the reset value of usable_frames, bitmap all free
    send_item(OP_TEST, '0, '0, 1'b0, 1'b0);            // fresh bitmap reads free
    send_item(OP_ALLOC, '0, '0, 1'b1, 1'b0);           // kernel read-only page
    send_item(OP_ALLOC, '0, '0, 1'b0, 1'b1);           // user writable page
    send_item(OP_ALLOC, '1, 20'hFFFFF, 1'b1, 1'b1);    // entry already mapped
    send_item(OP_ALLOC, '0, 20'h00001, 1'b0, 1'b0);    // smallest mapped entry
    send_item(OP_MARK, 12'd4095, '0, 1'b0, 1'b0);      // top frame
    send_item(OP_TEST, 12'd4095, '0, 1'b1, 1'b1);
    send_item(OP_TEST, 12'd4094, '0, 1'b0, 1'b0);
    send_item(OP_MARK, 12'd2, '0, 1'b0, 1'b0);
    send_item(OP_ALLOC, '0, '0, 1'b0, 1'b0);           // skips the marked frame
    send_item(OP_TEST, 12'd2, '0, 1'b0, 1'b0);
    send_item(OP_MARK, 12'd0, '0, 1'b1, 1'b1);         // mark an allocated frame
    send_item(2'(OP_UNUSED), '1, 20'hFFFFF, 1'b1, 1'b1); // unused opcode, all ones
    send_item(2'(OP_UNUSED), '0, '0, 1'b0, 1'b0);
    send_item(OP_MARK, 12'd32, '0, 1'b0, 1'b0);        // first bit of word one
    send_item(OP_TEST, 12'd32, '0, 1'b0, 1'b0);
    send_item(OP_ALLOC, '0, '0, 1'b1, 1'b1);
    send_item(OP_TEST, 12'd4, '0, 1'b0, 1'b0);
    send_item(OP_TEST, 12'hAAA, '0, 1'b0, 1'b0);
    send_item(OP_ALLOC, 12'h555, 20'hAAAAA, 1'b0, 1'b1);

    // one word scanned: runs into a full bitmap
    write_usable(32);
    random_items(60, 70, 10, 64);
    // empty scan ranges
    write_usable(0);
    random_items(25, 60, 15, 64);
    write_usable(31);
    random_items(25, 60, 15, 64);
    // two whole words, the partial third word is never handed out
    write_usable(95);
    random_items(80, 60, 15, 128);
    // long stretch with no gaps on either side
    steady = 1'b1;
    write_usable(USABLE_RST);
    random_items(400, 50, 20, 512);
    steady = 1'b0;
    // register above the bitmap size, scan clamped to the bitmap
    write_usable(8191);
    random_items(250, 50, 20, 1024);
    write_usable(4095);
    random_items(200, 35, 40, 2048);
    write_usable(USABLE_RST);
    random_items(200, 50, 20, 1024);

    drain_results();
    repeat (140) @(posedge clk_i);
    if (sb.pending_results.size() != 0) begin
      $display("%0t: %0d result items never arrived", $time,
               sb.pending_results.size());
      sb.errors++;
    end
    $display("run covered %0d items: %0d frames granted, %0d already mapped, %0d no free frame",
             sb.n_items, sb.n_granted, sb.n_mapped, sb.n_full);
    $display("usable_frames stepped through 0 to 8191, %0d tests found a used frame",
             sb.n_used_hits);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- bitmap_frame_allocator_core.f -----
hw/rtl/bfa_pkg.sv
hw/rtl/bfa_bitmap_ram.sv
hw/rtl/bfa_apb_regs.sv
hw/rtl/bfa_ctrl.sv
hw/rtl/bitmap_frame_allocator_core.sv
test/bitmap_frame_allocator_core_test.sv
